// ----- src/es2c_pkg.sv -----
// es2c_pkg: word types and calendar constants for the epoch seconds to calendar unit
// no dependencies; used by the channel interfaces and the top level

package es2c_pkg;

    localparam int UTC_W    = 32;
    localparam int ZONE_W   = 12;
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int WDAY_W   = 3;

    // offset limit in minutes, one day either way
    localparam logic signed [ZONE_W-1:0] ZONE_LIMIT = 12'sd1440;

    // first second of 2100-01-01 in local time
    localparam logic [32:0] END_SECONDS = 33'd4102444800;

    // calendar anchors: counting starts at 1968-01-01, the leap year before the epoch
    localparam logic [YEAR_W-1:0] BASE_YEAR = 12'd1968;
    localparam logic [15:0] DAYS_1968_TO_1970 = 16'd731;

    typedef struct packed {
        logic [UTC_W-1:0] utc_seconds;
    } stamp_word_t;

    typedef struct packed {
        logic [YEAR_W-1:0]   cal_year;
        logic [MONTH_W-1:0]  cal_month;
        logic [DAY_W-1:0]    cal_day;
        logic [HOUR_W-1:0]   clock_hour;
        logic [MINUTE_W-1:0] clock_minute;
        logic [SECOND_W-1:0] clock_second;
        logic [WDAY_W-1:0]   week_day;
        logic                out_of_range;
    } cal_word_t;

endpackage

// ----- src/es2c_stamp_if.sv -----
// es2c_stamp_if: valid/ready channel that carries one utc timestamp word
// depends on es2c_pkg for the word type

interface es2c_stamp_if import es2c_pkg::*; ();

    logic        valid;
    logic        ready;
    stamp_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

// ----- src/es2c_cal_if.sv -----
// es2c_cal_if: valid/ready channel that carries one calendar result word
// depends on es2c_pkg for the word type

interface es2c_cal_if import es2c_pkg::*; ();

    logic      valid;
    logic      ready;
    cal_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

// ----- src/epoch_seconds_to_calendar_unit.sv -----
// epoch_seconds_to_calendar_unit: utc seconds to local calendar date and time of day
// depends on es2c_pkg, es2c_stamp_if and es2c_cal_if
//
// usage
//   stamp: valid/ready sink, one word = utc_seconds since 1970-01-01 00:00:00
//   cal:   valid/ready source, one word = year, month, day, hour, minute, second,
//          weekday (0 sunday) and out_of_range
//   cfg_wr_en/cfg_wr_data: writes the zone offset in minutes (signed), saturated
//          to +/-1440 on write; write it only while the unit is empty
//   a word is taken on every cycle in which stamp.ready is high, so the rate is
//   one word per clock; the result leaves the output register after the word
//   has passed the eight register stages of the divide-by-constant and
//   calendar pipeline
//   local time before 1970 reads as 1970-01-01 00:00:00, after 2099 as
//   2099-12-31 23:59:59, both with out_of_range set
//   when cal.ready is low with a word waiting, the whole pipe holds and
//   stamp.ready drops in the same cycle; nothing is lost
//   reset empties the pipe and clears the zone offset to zero

module epoch_seconds_to_calendar_unit
    import es2c_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic signed [ZONE_W-1:0]  cfg_wr_data,
    es2c_stamp_if.sink                stamp,
    es2c_cal_if.source                cal
);

    localparam int PIPE_DEPTH = 8;

    // reciprocal multipliers, exact over the value range of each stage
    localparam logic [25:0] DIV675_MUL  = 26'd50903317;  // shift 35
    localparam logic [16:0] DIV1461_MUL = 17'd91868;     // shift 27
    localparam logic [17:0] DIV3600_MUL = 18'd149131;    // shift 29
    localparam logic [16:0] DIV7_MUL    = 17'd74899;     // shift 19
    localparam logic [12:0] DIV60_MUL   = 13'd4370;      // shift 18

    // first day of each month within a common year
    localparam logic [8:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // control
    logic                    advance;
    logic [PIPE_DEPTH-1:0]   stage_valid_reg;
    logic [PIPE_DEPTH-1:0]   stage_valid_next;
    logic signed [17:0]      zone_seconds_reg;
    logic signed [17:0]      zone_seconds_next;
    logic signed [ZONE_W-1:0] zone_sat;

    // stage 1
    logic [UTC_W-1:0]  utc_reg;
    logic [UTC_W-1:0]  utc_next;
    // stage 2
    logic [33:0]       local_sum;
    logic [31:0]       local_reg;
    logic [31:0]       local_next;
    logic              flag2_reg;
    logic              flag2_next;
    // stage 3
    logic [50:0]       prod3_reg;
    logic [50:0]       prod3_next;
    logic [24:0]       x3_reg;
    logic [24:0]       x3_next;
    logic [6:0]        low3_reg;
    logic [6:0]        low3_next;
    logic              flag3_reg;
    logic              flag3_next;
    // stage 4
    logic [15:0]       days4;
    logic [24:0]       days_x675;
    logic [24:0]       rem675;
    logic [15:0]       dp4_reg;
    logic [15:0]       dp4_next;
    logic [15:0]       wk4_reg;
    logic [15:0]       wk4_next;
    logic [16:0]       sod4_reg;
    logic [16:0]       sod4_next;
    logic              flag4_reg;
    logic              flag4_next;
    // stage 5
    logic [32:0]       qprod5_reg;
    logic [32:0]       qprod5_next;
    logic [34:0]       hprod5_reg;
    logic [34:0]       hprod5_next;
    logic [32:0]       wprod5_reg;
    logic [32:0]       wprod5_next;
    logic [15:0]       dp5_reg;
    logic [15:0]       dp5_next;
    logic [15:0]       wk5_reg;
    logic [15:0]       wk5_next;
    logic [16:0]       sod5_reg;
    logic [16:0]       sod5_next;
    logic              flag5_reg;
    logic              flag5_next;
    // stage 6
    logic [15:0]       quad_x1461;
    logic [16:0]       hour_x3600;
    logic [13:0]       wk_quot;
    logic [15:0]       wk_x7;
    logic [5:0]        quad6_reg;
    logic [5:0]        quad6_next;
    logic [10:0]       rem6_reg;
    logic [10:0]       rem6_next;
    logic [HOUR_W-1:0] hour6_reg;
    logic [HOUR_W-1:0] hour6_next;
    logic [11:0]       rest6_reg;
    logic [11:0]       rest6_next;
    logic [WDAY_W-1:0] wd6_reg;
    logic [WDAY_W-1:0] wd6_next;
    logic              flag6_reg;
    logic              flag6_next;
    // stage 7
    logic [1:0]         year_in_quad;
    logic [8:0]         doy;
    logic               leap;
    logic [8:0]         mstart [12];
    logic [MONTH_W-1:0] month_idx;
    logic [YEAR_W-1:0]  year7_reg;
    logic [YEAR_W-1:0]  year7_next;
    logic [MONTH_W-1:0] month7_reg;
    logic [MONTH_W-1:0] month7_next;
    logic [DAY_W-1:0]   day7_reg;
    logic [DAY_W-1:0]   day7_next;
    logic [HOUR_W-1:0]  hour7_reg;
    logic [HOUR_W-1:0]  hour7_next;
    logic [24:0]        mprod7_reg;
    logic [24:0]        mprod7_next;
    logic [11:0]        rest7_reg;
    logic [11:0]        rest7_next;
    logic [WDAY_W-1:0]  wd7_reg;
    logic [WDAY_W-1:0]  wd7_next;
    logic               flag7_reg;
    logic               flag7_next;
    // stage 8, output register
    logic [MINUTE_W-1:0] minute8;
    logic [11:0]         min_x60;
    cal_word_t           cal_reg;
    cal_word_t           cal_next;

    // the pipe moves as one unless a finished word waits at the output
    assign advance     = !stage_valid_reg[PIPE_DEPTH-1] || cal.ready;
    assign stamp.ready = advance;
    assign cal.valid   = stage_valid_reg[PIPE_DEPTH-1];
    assign cal.data    = cal_reg;

    assign stage_valid_next = {stage_valid_reg[PIPE_DEPTH-2:0], stamp.valid};

    // zone offset saturated and scaled to seconds at write time
    always_comb
    begin
        priority if (cfg_wr_data < -ZONE_LIMIT)
        begin
            zone_sat = -ZONE_LIMIT;
        end
        else if (cfg_wr_data > ZONE_LIMIT)
        begin
            zone_sat = ZONE_LIMIT;
        end
        else
        begin
            zone_sat = cfg_wr_data;
        end
        zone_seconds_next = {{(18 - ZONE_W){zone_sat[ZONE_W-1]}}, zone_sat} * 18'sd60;
    end

    // stage 1 -> 2: local time and range clamp
    assign utc_next  = stamp.data.utc_seconds;
    assign local_sum = {2'b00, utc_reg} + {{16{zone_seconds_reg[17]}}, zone_seconds_reg};

    always_comb
    begin
        priority if (local_sum[33])
        begin
            local_next = '0;
            flag2_next = 1'b1;
        end
        else if (local_sum[32:0] >= END_SECONDS)
        begin
            local_next = 32'(END_SECONDS - 33'd1);
            flag2_next = 1'b1;
        end
        else
        begin
            local_next = local_sum[31:0];
            flag2_next = 1'b0;
        end
    end

    // stage 2 -> 3: divide by 86400 = 128 * 675, reciprocal product for the 675 part
    assign x3_next    = local_reg[31:7];
    assign low3_next  = local_reg[6:0];
    assign prod3_next = local_reg[31:7] * DIV675_MUL;
    assign flag3_next = flag2_reg;

    // stage 3 -> 4: day count and second of day
    assign days4      = prod3_reg[50:35];
    assign days_x675  = {9'd0, days4} * 25'd675;
    assign rem675     = x3_reg - days_x675;
    assign sod4_next  = {rem675[9:0], low3_reg};
    assign dp4_next   = days4 + DAYS_1968_TO_1970;
    assign wk4_next   = days4 + 16'd4;
    assign flag4_next = flag3_reg;

    // stage 4 -> 5: reciprocal products for years, hours and weekday
    assign qprod5_next = dp4_reg * DIV1461_MUL;
    assign hprod5_next = sod4_reg * DIV3600_MUL;
    assign wprod5_next = wk4_reg * DIV7_MUL;
    assign dp5_next    = dp4_reg;
    assign wk5_next    = wk4_reg;
    assign sod5_next   = sod4_reg;
    assign flag5_next  = flag4_reg;

    // stage 5 -> 6: quotients and remainders
    assign quad6_next = qprod5_reg[32:27];
    assign quad_x1461 = {10'd0, qprod5_reg[32:27]} * 16'd1461;
    assign rem6_next  = 11'(dp5_reg - quad_x1461);
    assign hour6_next = hprod5_reg[33:29];
    assign hour_x3600 = {12'd0, hprod5_reg[33:29]} * 17'd3600;
    assign rest6_next = 12'(sod5_reg - hour_x3600);
    assign wk_quot    = wprod5_reg[32:19];
    assign wk_x7      = {2'd0, wk_quot} * 16'd7;
    assign wd6_next   = 3'(wk5_reg - wk_x7);
    assign flag6_next = flag5_reg;

    // stage 6 -> 7: year within the four-year cycle, then month and day
    // every century year in range is a multiple of 400, so the cycle never breaks
    always_comb
    begin
        priority if (rem6_reg < 11'd366)
        begin
            year_in_quad = 2'd0;
            doy          = rem6_reg[8:0];
        end
        else if (rem6_reg < 11'd731)
        begin
            year_in_quad = 2'd1;
            doy          = 9'(rem6_reg - 11'd366);
        end
        else if (rem6_reg < 11'd1096)
        begin
            year_in_quad = 2'd2;
            doy          = 9'(rem6_reg - 11'd731);
        end
        else
        begin
            year_in_quad = 2'd3;
            doy          = 9'(rem6_reg - 11'd1096);
        end
        leap = (year_in_quad == 2'd0);

        for (int i = 0; i < 12; i++)
        begin
            mstart[i] = MONTH_START[i] + {8'd0, (leap && (i >= 2))};
        end

        month_idx = '0;
        for (int i = 1; i < 12; i++)
        begin
            if (doy >= mstart[i])
            begin
                month_idx = MONTH_W'(i);
            end
        end

        year7_next  = BASE_YEAR + {4'd0, quad6_reg, 2'b00} + {10'd0, year_in_quad};
        month7_next = month_idx + 4'd1;
        day7_next   = 5'(doy - mstart[month_idx] + 9'd1);
    end

    assign hour7_next  = hour6_reg;
    assign mprod7_next = rest6_reg * DIV60_MUL;
    assign rest7_next  = rest6_reg;
    assign wd7_next    = wd6_reg;
    assign flag7_next  = flag6_reg;

    // stage 7 -> 8: minute and second
    assign minute8 = mprod7_reg[23:18];
    assign min_x60 = {6'd0, minute8} * 12'd60;

    always_comb
    begin
        cal_next.cal_year     = year7_reg;
        cal_next.cal_month    = month7_reg;
        cal_next.cal_day      = day7_reg;
        cal_next.clock_hour   = hour7_reg;
        cal_next.clock_minute = minute8;
        cal_next.clock_second = 6'(rest7_reg - min_x60);
        cal_next.week_day     = wd7_reg;
        cal_next.out_of_range = flag7_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= '0;
            zone_seconds_reg <= '0;
        end
        else
        begin
            if (advance)
            begin
                stage_valid_reg <= stage_valid_next;
            end
            if (cfg_wr_en)
            begin
                zone_seconds_reg <= zone_seconds_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            utc_reg    <= utc_next;

            local_reg  <= local_next;
            flag2_reg  <= flag2_next;

            prod3_reg  <= prod3_next;
            x3_reg     <= x3_next;
            low3_reg   <= low3_next;
            flag3_reg  <= flag3_next;

            dp4_reg    <= dp4_next;
            wk4_reg    <= wk4_next;
            sod4_reg   <= sod4_next;
            flag4_reg  <= flag4_next;

            qprod5_reg <= qprod5_next;
            hprod5_reg <= hprod5_next;
            wprod5_reg <= wprod5_next;
            dp5_reg    <= dp5_next;
            wk5_reg    <= wk5_next;
            sod5_reg   <= sod5_next;
            flag5_reg  <= flag5_next;

            quad6_reg  <= quad6_next;
            rem6_reg   <= rem6_next;
            hour6_reg  <= hour6_next;
            rest6_reg  <= rest6_next;
            wd6_reg    <= wd6_next;
            flag6_reg  <= flag6_next;

            year7_reg  <= year7_next;
            month7_reg <= month7_next;
            day7_reg   <= day7_next;
            hour7_reg  <= hour7_next;
            mprod7_reg <= mprod7_next;
            rest7_reg  <= rest7_next;
            wd7_reg    <= wd7_next;
            flag7_reg  <= flag7_next;

            cal_reg    <= cal_next;
        end
    end

endmodule
